// ===== rtl/core/cfrp_pkg.sv =====
// Shared types and constants for the configuration frame record parser.
// Used by cfrp_parser and config_frame_record_parser; depends on nothing.
package cfrp_pkg;

	// default depth of each mapping table
	localparam int MAX_MAPPINGS_DEF = 64;

	// parser phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SET_HEAD,
		PH_SET_VALUE,
		PH_MAPPING,
		PH_PENDING,
		PH_DONE
	} phase_t;

	// event kinds
	localparam logic [1:0] EV_SETTING = 2'd0;
	localparam logic [1:0] EV_MAPPING = 2'd1;
	localparam logic [1:0] EV_ACCEPT  = 2'd2;
	localparam logic [1:0] EV_REJECT  = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_LENGTH   = 3'd1;
	localparam logic [2:0] ERR_ID       = 3'd2;
	localparam logic [2:0] ERR_RANGE    = 3'd3;
	localparam logic [2:0] ERR_TYPE     = 3'd4;
	localparam logic [2:0] ERR_OVERFLOW = 3'd5;

	// object indices and ranges
	localparam logic [15:0] IDX_MODULE_ID = 16'h6081;
	localparam logic [15:0] IDX_OFFSET    = 16'h6084;
	localparam logic [15:0] IDX_S1        = 16'h6085;
	localparam logic [15:0] IDX_S2        = 16'h6086;
	localparam logic [15:0] IDX_S3        = 16'h6087;
	localparam logic [15:0] IDX_S4        = 16'h6088;
	localparam logic [15:0] IDX_CYCLE     = 16'h608A;
	localparam logic [15:0] IDX_LOW       = 16'h6000;
	localparam logic [15:0] IDX_HIGH      = 16'h7FFF;

	// setting store slots
	localparam logic [2:0] SLOT_OFFSET = 3'd0;
	localparam logic [2:0] SLOT_CYCLE  = 3'd5;

	// mapping record types
	localparam logic [7:0] MAP_TYPE_RX = 8'h1A;
	localparam logic [7:0] MAP_TYPE_TX = 8'h1B;

	typedef struct packed {
		logic       hit;
		logic [2:0] slot;
	} slot_hit_t;

	// one result word from the parser
	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [2:0]  err;
		logic [15:0] err_content;
		logic [15:0] set_index;
		logic [31:0] set_value;
		logic        direction;
		logic [5:0]  table_slot;
		logic [15:0] elem_addr;
		logic [7:0]  elem_type;
		logic [7:0]  byte_len;
		logic [15:0] frame_offset;
	} result_t;

	// map a setting index to its store slot
	function automatic slot_hit_t store_slot(input logic [15:0] idx);
		slot_hit_t r;
		r.hit  = 1'b1;
		r.slot = SLOT_OFFSET;
		case (idx)
			IDX_OFFSET: r.slot = SLOT_OFFSET;
			IDX_S1:     r.slot = 3'd1;
			IDX_S2:     r.slot = 3'd2;
			IDX_S3:     r.slot = 3'd3;
			IDX_S4:     r.slot = 3'd4;
			IDX_CYCLE:  r.slot = SLOT_CYCLE;
			default:    r.hit  = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/cfrp_parser.sv =====
// Byte-wise frame parser: phase machine, setting store and mapping table memories.
// Depends on cfrp_pkg.
module cfrp_parser #(
	parameter int MAX_MAPPINGS = cfrp_pkg::MAX_MAPPINGS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [7:0]           data_byte,
	input  logic                 frame_start,
	input  logic [31:0]          expected_id,
	output cfrp_pkg::result_t    res
);

	localparam int CW = $clog2(MAX_MAPPINGS + 1);
	localparam int AW = $clog2(2 * MAX_MAPPINGS);

	// control state
	cfrp_pkg::phase_t phase_q, phase_d;
	logic [2:0]       cnt_q, cnt_d;
	logic [15:0]      set_left_q, set_left_d;
	logic [15:0]      map_left_q, map_left_d;
	logic [15:0]      idx_q, idx_d;
	logic [7:0]       len_q, len_d;
	logic [31:0]      acc_q, acc_d;
	logic [CW-1:0]    fill_q [2];
	logic [CW-1:0]    fill_d [2];

	// setting store memory, valid bits, registered read of the offset entry
	logic [31:0] set_mem [6];
	logic [5:0]  set_vld_q;
	logic [31:0] set0_q;
	logic        set_we;
	logic [2:0]  set_waddr;
	logic [31:0] set_wdata;

	// mapping table memory, write only
	logic [47:0]   map_mem [2*MAX_MAPPINGS];
	logic          map_we;
	logic [AW-1:0] map_waddr;
	logic [47:0]   map_wdata;

	// working values
	logic                go_next, had_res, restart;
	logic [31:0]         shifted, acc_sv, value;
	logic [3:0]          cnt1;
	cfrp_pkg::slot_hit_t sh;
	logic                dir;
	logic [CW-1:0]       slot;
	logic [15:0]         offset;

	// next state and result for the current byte
	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		set_left_d = set_left_q;
		map_left_d = map_left_q;
		idx_d      = idx_q;
		len_d      = len_q;
		acc_d      = acc_q;
		fill_d     = fill_q;
		res        = '0;
		set_we     = 1'b0;
		set_waddr  = cfrp_pkg::SLOT_OFFSET;
		map_we     = 1'b0;
		go_next    = 1'b0;
		had_res    = 1'b0;
		restart    = 1'b0;

		shifted = 32'(data_byte) << {cnt_q[1:0], 3'b000};
		acc_sv  = (cnt_q < 3'd4) ? (acc_q | shifted) : acc_q;
		cnt1    = {1'b0, cnt_q} + 4'd1;
		sh      = cfrp_pkg::store_slot(idx_q);
		value   = acc_sv;
		if (sh.hit && sh.slot == cfrp_pkg::SLOT_CYCLE && acc_sv == 32'd0)
			value = 32'd1;
		set_wdata = value;

		dir       = (len_q == cfrp_pkg::MAP_TYPE_TX);
		slot      = fill_q[dir];
		offset    = {data_byte, idx_q[7:0]} + set0_q[15:0];
		map_waddr = AW'(slot) + (dir ? AW'(MAX_MAPPINGS) : AW'(0));
		map_wdata = {offset, acc_q};

		if (phase_q == cfrp_pkg::PH_PENDING) begin
			res.valid = 1'b1;
			res.kind  = cfrp_pkg::EV_ACCEPT;
			phase_d   = cfrp_pkg::PH_DONE;
			restart   = frame_start;
		end else if (frame_start) begin
			restart = 1'b1;
		end else begin
			case (phase_q)
				cfrp_pkg::PH_HEADER: begin
					cnt_d = cnt_q + 3'd1;
					case (cnt_q)
						3'd4: set_left_d = {8'd0, data_byte};
						3'd5: set_left_d = {data_byte, set_left_q[7:0]};
						3'd6: map_left_d = {8'd0, data_byte};
						3'd7: begin
							map_left_d = {data_byte, map_left_q[7:0]};
							if (map_left_d > 16'(MAX_MAPPINGS)) begin
								res.valid       = 1'b1;
								res.kind        = cfrp_pkg::EV_REJECT;
								res.err         = cfrp_pkg::ERR_OVERFLOW;
								res.err_content = map_left_d;
								phase_d         = cfrp_pkg::PH_DONE;
							end else begin
								go_next = 1'b1;
							end
						end
						default: ;
					endcase
				end

				cfrp_pkg::PH_SET_HEAD: begin
					cnt_d = cnt_q + 3'd1;
					case (cnt_q)
						3'd1: idx_d = {8'd0, data_byte};
						3'd2: idx_d = {data_byte, idx_q[7:0]};
						3'd3: begin
							len_d = data_byte;
							if (data_byte != 8'd1 && data_byte != 8'd2 && data_byte != 8'd4) begin
								res.valid       = 1'b1;
								res.kind        = cfrp_pkg::EV_REJECT;
								res.err         = cfrp_pkg::ERR_LENGTH;
								res.err_content = {8'd0, data_byte};
								phase_d         = cfrp_pkg::PH_DONE;
							end else begin
								acc_d   = '0;
								cnt_d   = 3'd0;
								phase_d = cfrp_pkg::PH_SET_VALUE;
							end
						end
						default: ;
					endcase
				end

				cfrp_pkg::PH_SET_VALUE: begin
					acc_d = acc_sv;
					cnt_d = cnt1[2:0];
					if (8'(cnt1) >= len_q) begin
						set_left_d = set_left_q - 16'd1;
						if (idx_q == cfrp_pkg::IDX_MODULE_ID) begin
							if (acc_sv != expected_id) begin
								res.valid       = 1'b1;
								res.kind        = cfrp_pkg::EV_REJECT;
								res.err         = cfrp_pkg::ERR_ID;
								res.err_content = acc_sv[15:0];
								phase_d         = cfrp_pkg::PH_DONE;
							end else begin
								go_next = 1'b1;
							end
						end else if (!sh.hit) begin
							if (idx_q < cfrp_pkg::IDX_LOW || idx_q > cfrp_pkg::IDX_HIGH) begin
								res.valid       = 1'b1;
								res.kind        = cfrp_pkg::EV_REJECT;
								res.err         = cfrp_pkg::ERR_RANGE;
								res.err_content = idx_q;
								phase_d         = cfrp_pkg::PH_DONE;
							end else begin
								go_next = 1'b1;
							end
						end else begin
							set_we        = 1'b1;
							set_waddr     = sh.slot;
							res.valid     = 1'b1;
							res.kind      = cfrp_pkg::EV_SETTING;
							res.set_index = idx_q;
							res.set_value = value;
							go_next       = 1'b1;
							had_res       = 1'b1;
						end
					end
				end

				cfrp_pkg::PH_MAPPING: begin
					cnt_d = cnt_q + 3'd1;
					case (cnt_q)
						3'd0: begin
							if (data_byte != cfrp_pkg::MAP_TYPE_RX &&
									data_byte != cfrp_pkg::MAP_TYPE_TX) begin
								res.valid       = 1'b1;
								res.kind        = cfrp_pkg::EV_REJECT;
								res.err         = cfrp_pkg::ERR_TYPE;
								res.err_content = {8'd0, data_byte};
								phase_d         = cfrp_pkg::PH_DONE;
							end else begin
								len_d = data_byte;
								acc_d = '0;
							end
						end
						3'd1: acc_d = {24'd0, data_byte};
						3'd2: acc_d = {acc_q[31:16], data_byte, acc_q[7:0]};
						3'd3: acc_d = {acc_q[31:24], data_byte, acc_q[15:0]};
						3'd4: acc_d = {data_byte, acc_q[23:0]};
						3'd5: idx_d = {8'd0, data_byte};
						3'd6: begin
							map_we           = (32'(slot) < 32'(MAX_MAPPINGS));
							fill_d[dir]      = slot + CW'(1);
							map_left_d       = map_left_q - 16'd1;
							res.valid        = 1'b1;
							res.kind         = cfrp_pkg::EV_MAPPING;
							res.direction    = dir;
							res.table_slot   = 6'(slot);
							res.elem_addr    = acc_q[15:0];
							res.elem_type    = acc_q[23:16];
							res.byte_len     = acc_q[31:24];
							res.frame_offset = offset;
							go_next          = 1'b1;
							had_res          = 1'b1;
						end
						default: ;
					endcase
				end

				default: ;
			endcase
		end

		// pick the next record, or close the frame
		if (go_next) begin
			cnt_d = 3'd0;
			if (set_left_d != 16'd0) begin
				phase_d = cfrp_pkg::PH_SET_HEAD;
			end else if (map_left_d != 16'd0) begin
				phase_d = cfrp_pkg::PH_MAPPING;
			end else if (had_res) begin
				phase_d = cfrp_pkg::PH_PENDING;
			end else begin
				res.valid = 1'b1;
				res.kind  = cfrp_pkg::EV_ACCEPT;
				phase_d   = cfrp_pkg::PH_DONE;
			end
		end

		// new frame: this byte is header byte zero
		if (restart) begin
			phase_d    = cfrp_pkg::PH_HEADER;
			cnt_d      = 3'd1;
			set_left_d = '0;
			map_left_d = '0;
			fill_d[0]  = '0;
			fill_d[1]  = '0;
		end
	end

	// state registers, advanced on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= cfrp_pkg::PH_IDLE;
			cnt_q      <= '0;
			set_left_q <= '0;
			map_left_q <= '0;
			idx_q      <= '0;
			len_q      <= '0;
			acc_q      <= '0;
			fill_q[0]  <= '0;
			fill_q[1]  <= '0;
			set_vld_q  <= '0;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			set_left_q <= set_left_d;
			map_left_q <= map_left_d;
			idx_q      <= idx_d;
			len_q      <= len_d;
			acc_q      <= acc_d;
			fill_q[0]  <= fill_d[0];
			fill_q[1]  <= fill_d[1];
			if (set_we)
				set_vld_q[set_waddr] <= 1'b1;
		end
	end

	// setting store: one write port, registered read of the offset entry.
	// A write reaches the read register through set_mem and then set0_q; a mapping
	// record that uses the offset comes at least seven bytes after any setting.
	always_ff @(posedge clk) begin
		if (in_fire && set_we)
			set_mem[set_waddr] <= set_wdata;
		set0_q <= set_vld_q[cfrp_pkg::SLOT_OFFSET] ? set_mem[cfrp_pkg::SLOT_OFFSET] : '0;
	end

	// mapping table: {offset, byte length, element type, address}
	always_ff @(posedge clk) begin
		if (in_fire && map_we)
			map_mem[map_waddr] <= map_wdata;
	end

endmodule

// ===== rtl/core/config_frame_record_parser.sv =====
// Configuration frame record parser: one frame byte per word in, one event word out.
// Each event word is registered in the output or skid word before it is offered on m_tvalid.
// Throughput: one byte per cycle while the skid word is empty; a two-word output
// buffer keeps s_tready high while one event waits. Reset clears the phase machine,
// counters, setting valid bits and the expected module number; the mapping table holds
// no reset value and is only written. Depends on cfrp_pkg and cfrp_parser.
module config_frame_record_parser #(
	parameter int MAX_MAPPINGS = cfrp_pkg::MAX_MAPPINGS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // data_byte
	input  logic         s_tuser,  // frame_start
	output logic         m_tvalid,
	input  logic         m_tready,
	// error_code, error_content, setting_index, setting_value, direction,
	// table_slot, element_address, element_type, byte_length, frame_offset, zero pad
	output logic [127:0] m_tdata,
	output logic [1:0]   m_tuser   // event_kind
);

	logic              in_fire;
	logic [31:0]       expected_q;
	cfrp_pkg::result_t res;
	cfrp_pkg::result_t out_q, skid_q;
	logic              out_v_q, skid_v_q;
	logic              pop, push;

	// expected module number register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
		end else if (cfg_we) begin
			expected_q <= cfg_wdata;
		end
	end

	assign s_tready = !skid_v_q;
	assign in_fire  = s_tvalid && s_tready;

	cfrp_parser #(
		.MAX_MAPPINGS(MAX_MAPPINGS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.data_byte   (s_tdata),
		.frame_start (s_tuser),
		.expected_id (expected_q),
		.res         (res)
	);

	assign pop  = out_v_q && m_tready;
	assign push = in_fire && res.valid;

	// output word plus skid word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !pop) begin
			if (push)
				skid_v_q <= 1'b1;
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= push;
		end else begin
			out_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !pop) begin
			if (push)
				skid_q <= res;
		end else if (skid_v_q) begin
			out_q <= skid_q;
			if (push)
				skid_q <= res;
		end else if (push) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {6'd0, out_q.frame_offset, out_q.byte_len, out_q.elem_type,
		out_q.elem_addr, out_q.table_slot, out_q.direction, out_q.set_value,
		out_q.set_index, out_q.err_content, out_q.err};

endmodule
